/* src/sfra_pkg.sv */
// shared types and constants for the sprite frame range animator
// used by sfra_ctrl, sfra_dpath and the top level; no dependencies
package sfra_pkg;

    localparam int MAX_STEPS = 8;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_FRAME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_FOREVER  = 3'd4;

    localparam logic OP_PROGRESS = 1'b0;
    localparam logic OP_START    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] step_delay;
        logic [7:0]  first_frame;
        logic [7:0]  final_frame;
        logic [15:0] repeat_target;
        logic        loop_forever;
    } t_cfg;

    typedef struct packed {
        logic start;      // restart the run at the given time
        logic latch_now;  // capture the progress time, clear the step count
        logic step;       // take one frame step
    } t_cmd;

    typedef struct packed {
        logic more;       // another step is due for this word
    } t_sts;

endpackage

/* src/sprite_frame_range_animator_unit.sv */
// a start word gives no result; a progress word is latched and evaluated in
// ST_EVAL, then each of its k steps takes one step state and one output state
// (ST_STEP, ST_EMIT), limited by the single step unit and held while the output
// stalls; one word is handled at a time
// reset: synchronous active low, clears run state and loads register defaults
// top level of the sprite frame range animator; depends on sfra_pkg,
// sfra_ctrl and sfra_dpath; holds the configuration registers
module sprite_frame_range_animator_unit
    import sfra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] now_time
    input  logic                 s_axis_tuser,   // [0] opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // [7:0] frame_index, [23:8] pass_count,
                                                 // [24] finished, [31:25] zero
    output logic                 m_axis_tlast    // last_of_run
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay    <= 16'd1;
            r_cfg.first_frame   <= '0;
            r_cfg.final_frame   <= '0;
            r_cfg.repeat_target <= 16'd1;
            r_cfg.loop_forever  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_DELAY:    r_cfg.step_delay    <= i_cfg_data;
                REG_FIRST_FRAME:   r_cfg.first_frame   <= i_cfg_data[7:0];
                REG_FINAL_FRAME:   r_cfg.final_frame   <= i_cfg_data[7:0];
                REG_REPEAT_TARGET: r_cfg.repeat_target <= i_cfg_data;
                REG_LOOP_FOREVER:  r_cfg.loop_forever  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sfra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_last  (m_axis_tlast),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    sfra_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_now    (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (m_axis_tdata)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_finish_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[24]) |-> m_axis_tlast)
        else $error("finished word not marked last");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after last word of a run");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.start, w_cmd.latch_now, w_cmd.step}))
        else $error("conflicting datapath commands");

endmodule

/* src/sfra_ctrl.sv */
// controller state machine for the sprite frame range animator
// depends on sfra_pkg; drives the datapath by t_cmd and reads t_sts
module sfra_ctrl
    import sfra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_out_last,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.start = 1'b1;
                    end else begin
                        o_cmd.latch_now = 1'b1;
                        n_state         = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                n_state = i_sts.more ? ST_STEP : ST_IDLE;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                // last flag looks ahead at the post-step state
                o_out_valid = 1'b1;
                o_out_last  = !i_sts.more;
                if (i_out_ready) begin
                    n_state = i_sts.more ? ST_STEP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* src/sfra_dpath.sv */
// datapath for the sprite frame range animator: run state and step logic
// depends on sfra_pkg; commanded by sfra_ctrl
module sfra_dpath
    import sfra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic [31:0]      i_now,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic [OUT_W-1:0] o_result
);

    logic [31:0]      r_last,    n_last;
    logic [7:0]       r_frame,   n_frame;
    logic [15:0]      r_passes,  n_passes;
    logic             r_running, n_running;
    logic             r_done,    n_done;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      w_elapsed;
    logic [15:0]      w_pass_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_frame   <= '0;
            r_passes  <= '0;
            r_running <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_last    <= n_last;
            r_frame   <= n_frame;
            r_passes  <= n_passes;
            r_running <= n_running;
            r_done    <= n_done;
            if (i_cmd.latch_now) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_now) begin
            r_now <= i_now;
        end
    end

    assign w_pass_inc = r_passes + 16'd1;

    always_comb begin
        n_last    = r_last;
        n_frame   = r_frame;
        n_passes  = r_passes;
        n_running = r_running;
        n_done    = r_done;
        if (i_cmd.start) begin
            n_last    = i_now;
            n_frame   = i_cfg.first_frame;
            n_passes  = '0;
            n_running = 1'b1;
            n_done    = 1'b0;
        end else if (i_cmd.step) begin
            n_frame = (r_frame == i_cfg.final_frame) ? i_cfg.first_frame
                                                     : r_frame + 8'd1;
            n_last  = r_last + {16'd0, i_cfg.step_delay};
            n_done  = 1'b0;
            if (n_frame == i_cfg.final_frame && !i_cfg.loop_forever) begin
                n_passes = w_pass_inc;
                if (w_pass_inc == i_cfg.repeat_target) begin
                    n_done    = 1'b1;
                    n_running = 1'b0;
                end
            end
        end
    end

    assign w_elapsed = r_now - r_last;

    // finishing clears running, so that also ends the word
    assign o_sts.more = r_running && (r_cnt < CNT_W'(MAX_STEPS)) && (r_now > r_last)
                        && (w_elapsed >= {16'd0, i_cfg.step_delay});

    assign o_result = {{(OUT_W - 25){1'b0}}, r_done, r_passes, r_frame};

endmodule

/* verif/testbench.sv */
// self-checking testbench for sprite_frame_range_animator_unit
// predicts the frame steps of every accepted word and checks them in order
// depends on sfra_pkg and the unit under test
module testbench;
    import sfra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 2 * MAX_STEPS + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_CAP    = 100;

    typedef struct {
        logic        op;
        logic [31:0] now;
    } t_word;

    typedef struct {
        logic [7:0]  frame;
        logic [15:0] pass_count;
        logic        finished;
        logic        last_of_run;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;   // [31:0] now_time
    logic                 s_axis_tuser = 1'b0; // [0] opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // [7:0] frame, [23:8] passes, [24] finished
    logic                 m_axis_tlast;

    // predictor state and register copy
    t_cfg        anim_cfg = '{step_delay: 16'd1, first_frame: 8'd0, final_frame: 8'd0,
                              repeat_target: 16'd1, loop_forever: 1'b0};
    logic [31:0] step_anchor = '0;
    logic [7:0]  shown_frame = '0;
    logic [15:0] passes = '0;
    logic        run_active = 1'b0;

    t_word words_to_send[$];
    t_step frames_due[$];
    int    active_words = 0;
    int    mismatches = 0;
    int    cycle_count = 0;
    bit    calm = 1'b0;

    sprite_frame_range_animator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_STEP_DELAY:    anim_cfg.step_delay    = val;
            REG_FIRST_FRAME:   anim_cfg.first_frame   = val[7:0];
            REG_FINAL_FRAME:   anim_cfg.final_frame   = val[7:0];
            REG_REPEAT_TARGET: anim_cfg.repeat_target = val;
            REG_LOOP_FOREVER:  anim_cfg.loop_forever  = val[0];
            default: ;
        endcase
    endfunction

    // steps the sprite for one accepted word and queues the frames it shows
    function automatic void advance_sprite(input logic op, input logic [31:0] now);
        int    taken;
        logic  done;
        t_step s;
        taken = 0;
        done = 1'b0;
        if (op == OP_START) begin
            step_anchor = now;
            shown_frame = anim_cfg.first_frame;
            passes = '0;
            run_active = 1'b1;
            active_words++;
            return;
        end
        if (!run_active) begin
            return;
        end
        active_words++;
        while (taken < MAX_STEPS && !done && now > step_anchor &&
               (now - step_anchor) >= 32'(anim_cfg.step_delay)) begin
            if (shown_frame == anim_cfg.final_frame) begin
                shown_frame = anim_cfg.first_frame;
            end else begin
                shown_frame = shown_frame + 8'd1;
            end
            step_anchor = step_anchor + 32'(anim_cfg.step_delay);
            if (shown_frame == anim_cfg.final_frame && !anim_cfg.loop_forever) begin
                passes = passes + 16'd1;
                if (passes == anim_cfg.repeat_target) begin
                    done = 1'b1;
                    run_active = 1'b0;
                end
            end
            s = '{frame: shown_frame, pass_count: passes, finished: done, last_of_run: 1'b0};
            frames_due = {frames_due, s};
            taken++;
        end
        if (taken > 0) begin
            frames_due[frames_due.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    // input side: one word in flight, the next one taken from the queue
    always @(posedge i_clk) begin
        t_word w;
        logic  slot_free;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            slot_free = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_sprite(s_axis_tuser, s_axis_tdata);
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                    w = words_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= w.op;
                    s_axis_tdata  <= w.now;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each word against the oldest predicted step
    always @(posedge i_clk) begin
        t_step want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frames_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h last %b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    want = frames_due.pop_front();
                    if (m_axis_tdata[7:0] !== want.frame)
                        report_mismatch($sformatf("frame %0d, want %0d",
                                                  m_axis_tdata[7:0], want.frame));
                    if (m_axis_tdata[23:8] !== want.pass_count)
                        report_mismatch($sformatf("pass count %0d, want %0d",
                                                  m_axis_tdata[23:8], want.pass_count));
                    if (m_axis_tdata[24] !== want.finished)
                        report_mismatch($sformatf("finished %b, want %b",
                                                  m_axis_tdata[24], want.finished));
                    if (m_axis_tdata[OUT_W-1:25] !== '0)
                        report_mismatch($sformatf("pad bits %h not zero",
                                                  m_axis_tdata[OUT_W-1:25]));
                    if (m_axis_tlast !== want.last_of_run)
                        report_mismatch($sformatf("tlast %b, want %b",
                                                  m_axis_tlast, want.last_of_run));
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void queue_word(input logic op, input logic [31:0] now);
        t_word w;
        w = '{op: op, now: now};
        words_to_send = {words_to_send, w};
    endfunction

    // valid stays high across back-to-back writes and drops once at the end
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic write_regs(input t_cfg c, input bit spare);
        cfg_put(REG_STEP_DELAY, c.step_delay);
        cfg_put(REG_FIRST_FRAME, {8'($urandom), c.first_frame});
        cfg_put(REG_FINAL_FRAME, {8'($urandom), c.final_frame});
        cfg_put(REG_REPEAT_TARGET, c.repeat_target);
        cfg_put(REG_LOOP_FOREVER, {15'($urandom), c.loop_forever});
        // unmapped indexes must leave the registers alone
        if (spare) begin
            cfg_put(CFG_IDX_W'(REG_LOOP_FOREVER + 1 + $urandom_range(2)), 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (words_to_send.size() != 0 || s_axis_tvalid || frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cfg pick_cfg();
        t_cfg c;
        case ($urandom_range(9))
            0:       c.step_delay = '0;
            1:       c.step_delay = '1;
            2:       c.step_delay = 16'($urandom);
            default: c.step_delay = 16'($urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
            0:       c.first_frame = '0;
            1:       c.first_frame = '1;
            default: c.first_frame = 8'($urandom);
        endcase
        // mostly short ranges so passes complete, sometimes final below first
        case ($urandom_range(9))
            0:       c.final_frame = 8'($urandom);
            1:       c.final_frame = c.first_frame - 8'($urandom_range(1, 3));
            default: c.final_frame = c.first_frame + 8'($urandom_range(5));
        endcase
        case ($urandom_range(9))
            0:       c.repeat_target = '0;
            1:       c.repeat_target = '1;
            default: c.repeat_target = 16'($urandom_range(1, 3));
        endcase
        c.loop_forever = ($urandom_range(4) == 0);
        return c;
    endfunction

    // a start word followed by progress words spaced by whole delays plus jitter, with stray words and restarts
    function automatic void queue_run(input t_cfg c);
        logic [31:0] t;
        int unsigned d;
        int unsigned n;
        d = (c.step_delay == 0) ? 1 : c.step_delay;
        case ($urandom_range(9))
            0:       t = '0;
            1:       t = 32'hFFFF_FFFF - 32'($urandom_range(d * 4));
            default: t = $urandom;
        endcase
        if ($urandom_range(9) == 0) begin
            queue_word(OP_PROGRESS, t);
        end
        queue_word(OP_START, t);
        n = $urandom_range(3, 10);
        repeat (n) begin
            case ($urandom_range(19))
                0: queue_word(OP_PROGRESS, $urandom);
                1: queue_word(OP_START, t);
                default: begin
                    t = t + d * $urandom_range(10) + $urandom_range(d - 1);
                    queue_word(OP_PROGRESS, t);
                end
            endcase
        end
    endfunction

    initial begin
        t_cfg cfg;
        int   phase;
        bit   quiet;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: idle progress ignored, then a single-frame range finishes at once
        queue_word(OP_PROGRESS, 32'd100);
        queue_word(OP_START, 32'd5);
        queue_word(OP_PROGRESS, 32'd5);
        queue_word(OP_PROGRESS, 32'd6);
        queue_word(OP_PROGRESS, 32'd50);
        drain();

        // short range, restart while running, time going backwards
        write_regs('{16'd3, 8'd10, 8'd13, 16'd2, 1'b0}, 1'b0);
        queue_word(OP_START, 32'd0);
        queue_word(OP_PROGRESS, 32'd3);
        queue_word(OP_PROGRESS, 32'd20);
        queue_word(OP_START, 32'd100);
        queue_word(OP_PROGRESS, 32'd99);
        queue_word(OP_PROGRESS, 32'd1000);
        queue_word(OP_PROGRESS, 32'd2000);
        drain();

        // zero delay, forever, zero repeat target, time at the top of the range
        write_regs('{16'd0, 8'd255, 8'd0, 16'd0, 1'b1}, 1'b1);
        queue_word(OP_START, 32'hFFFF_FFFF);
        queue_word(OP_PROGRESS, 32'hFFFF_FFFF);
        queue_word(OP_START, 32'hFFFF_FFF0);
        queue_word(OP_PROGRESS, 32'hFFFF_FFFF);
        drain();

        write_regs('{16'hFFFF, 8'd0, 8'd255, 16'hFFFF, 1'b0}, 1'b0);
        queue_word(OP_START, 32'd0);
        queue_word(OP_PROGRESS, 32'd65534);
        queue_word(OP_PROGRESS, 32'd65535);
        queue_word(OP_PROGRESS, 32'hFFFF_FFFF);
        drain();

        // final below first counts up from first; the word stops at the step cap
        write_regs('{16'd1, 8'd200, 8'd198, 16'd0, 1'b0}, 1'b0);
        queue_word(OP_START, 32'd10);
        queue_word(OP_PROGRESS, 32'd300);
        drain();

        phase = 0;
        while (active_words < ITEM_TARGET) begin
            quiet = (phase % 5 == 2);
            calm <= quiet;
            cfg = pick_cfg();
            write_regs(cfg, $urandom_range(3) == 0);
            repeat (quiet ? 8 : $urandom_range(2, 5)) queue_run(cfg);
            drain();
            phase++;
        end
        calm <= 1'b0;

        if (frames_due.size() != 0) begin
            report_mismatch($sformatf("%0d predicted steps never arrived", frames_due.size()));
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/sfra_pkg.sv
src/sfra_ctrl.sv
src/sfra_dpath.sv
src/sprite_frame_range_animator_unit.sv
verif/testbench.sv
